// File: src/mf3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and compare helpers for the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int CHANNEL_COUNT = 3;
    localparam int WINDOW_SIZE   = 9;
    localparam int CENTER_IDX    = 4;
    localparam int CHAN_W        = 8;
    localparam int PIXEL_CHANS   = 3;
    localparam int PIXEL_W       = CHAN_W * PIXEL_CHANS;
    localparam int WIN_W         = PIXEL_W * WINDOW_SIZE;
    // lane count is the smaller of CHANNEL_COUNT and PIXEL_CHANS, so every channel gets a lane
    localparam int LANE_COUNT    = (CHANNEL_COUNT < PIXEL_CHANS) ? CHANNEL_COUNT
                                                                 : PIXEL_CHANS;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef chan_t [WINDOW_SIZE-1:0] window_t;
    typedef chan_t [PIXEL_CHANS-1:0] lane_meds_t;

    typedef struct packed {
        logic en;
    } pipe_ctl_t;

    function automatic chan_t min2(input chan_t a, input chan_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic chan_t max2(input chan_t a, input chan_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic chan_t min3(input chan_t a, input chan_t b, input chan_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic chan_t max3(input chan_t a, input chan_t b, input chan_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

// File: src/mf3_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_lane
// One channel lane: two-stage median-of-nine network (row sort, then
// max of lows / median of mids / min of highs); final med3 feeds the merge.
// ----------------------------------------------------------------------------
module mf3_lane
    import mf3_pkg::*;
(
    input  logic      clk,
    input  pipe_ctl_t ctl,
    input  window_t   win,
    output chan_t     med
);

    chan_t [2:0] lo_reg;
    chan_t [2:0] mid_reg;
    chan_t [2:0] hi_reg;
    chan_t       mx_reg;
    chan_t       md_reg;
    chan_t       mn_reg;

    // stage 1: sort each window row
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                lo_reg[r]  <= min3(win[3*r], win[3*r+1], win[3*r+2]);
                mid_reg[r] <= med3(win[3*r], win[3*r+1], win[3*r+2]);
                hi_reg[r]  <= max3(win[3*r], win[3*r+1], win[3*r+2]);
            end
        end
    end

    // stage 2: median candidates across rows
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            mx_reg <= max3(lo_reg[0], lo_reg[1], lo_reg[2]);
            md_reg <= med3(mid_reg[0], mid_reg[1], mid_reg[2]);
            mn_reg <= min3(hi_reg[0], hi_reg[1], hi_reg[2]);
        end
    end

    assign med = med3(mx_reg, md_reg, mn_reg);

endmodule

// File: src/mf3_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_merge
// Output register: packs lane medians into one pixel, or passes the center
// pixel on the border and for channels that have no lane.
// ----------------------------------------------------------------------------
module mf3_merge
    import mf3_pkg::*;
(
    input  logic       clk,
    input  pipe_ctl_t  ctl,
    input  lane_meds_t meds,
    input  pixel_t     center,
    input  logic       on_border,
    output pixel_t     pixel
);

    pixel_t pixel_reg;
    pixel_t pixel_next;

    always_comb
    begin
        pixel_next = center;
        if (!on_border)
        begin
            for (int ch = 0; ch < LANE_COUNT; ch++)
            begin
                pixel_next[ch*CHAN_W +: CHAN_W] = meds[ch];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

// File: src/median_filter_3x3_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb
// Per-channel 3x3 median filter on packed B,G,R pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one 3x3 window per transfer: nine 24-bit pixels in
//   s_tdata (top_left lowest, bot_right highest) and on_border in s_tuser.
//   m_* channel returns one 24-bit filtered pixel per window, in order.
//   Each channel has its own lane computing the median of nine through a
//   two-stage compare network; a merge register assembles the pixel.
//   A window passes the lane stages and the merge register to m_tvalid.
//   Throughput is one window per cycle while m_tready is high; the shared
//   pipeline enable (output register free or being taken) sets that figure.
//   When on_border is set the center pixel comes out unchanged.
//   When the receiver stalls, the whole pipeline holds and s_tready drops
//   until the output transfer happens; nothing is lost or repeated.
//   Reset clears all valid flags; the block then has no results pending.
// ----------------------------------------------------------------------------
module median_filter_3x3_rgb
    import mf3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [WIN_W-1:0]   s_tdata,   // top_left, top_mid, top_right, mid_left,
                                          // center, mid_right, bot_left, bot_mid,
                                          // bot_right (24 bits each)
    input  logic [0:0]         s_tuser,   // on_border
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [PIXEL_W-1:0] m_tdata    // filtered_pixel
);

    pipe_ctl_t  ctl;
    lane_meds_t meds;
    logic       v1_reg;
    logic       v2_reg;
    logic       out_valid_reg;
    pixel_t     c1_reg;
    pixel_t     c2_reg;
    logic       b1_reg;
    logic       b2_reg;

    assign ctl.en   = !out_valid_reg || m_tready;
    assign s_tready = ctl.en;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    // center pixel and border flag follow the lane stages
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            c1_reg <= s_tdata[CENTER_IDX*PIXEL_W +: PIXEL_W];
            b1_reg <= s_tuser[0];
            c2_reg <= c1_reg;
            b2_reg <= b1_reg;
        end
    end

    genvar ch;
    generate
        for (ch = 0; ch < PIXEL_CHANS; ch++)
        begin : g_lane
            if (ch < LANE_COUNT)
            begin : g_on
                window_t win;
                always_comb
                begin
                    for (int k = 0; k < WINDOW_SIZE; k++)
                    begin
                        win[k] = s_tdata[k*PIXEL_W + ch*CHAN_W +: CHAN_W];
                    end
                end

                mf3_lane u_lane (
                    .clk (clk),
                    .ctl (ctl),
                    .win (win),
                    .med (meds[ch])
                );
            end
            else
            begin : g_off
                assign meds[ch] = '0;
            end
        end
    endgenerate

    mf3_merge u_merge (
        .clk       (clk),
        .ctl       (ctl),
        .meds      (meds),
        .center    (c2_reg),
        .on_border (b2_reg),
        .pixel     (m_tdata)
    );

    // assertions
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.en && v2_reg) |=> m_tvalid)
        else $error("pipeline item not presented at output");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.en && !v2_reg) |=> !m_tvalid)
        else $error("output valid without an item in the pipeline");

    a_border_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.en && v2_reg && b2_reg) |=> (m_tdata == $past(c2_reg)))
        else $error("border pixel not passed through");

endmodule

// File: test/median_filter_3x3_rgb_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb_tb
// Streams 3x3 pixel windows through the filter and checks every output pixel
// against a per-channel rank-order prediction. Border windows, extremes, ties
// and random windows run under phases of source idling and sink backpressure.
// ----------------------------------------------------------------------------
module median_filter_3x3_rgb_tb;
    import mf3_pkg::*;

    localparam int MEDIAN_RANK    = WINDOW_SIZE / 2;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct packed {
        logic             border;
        logic [WIN_W-1:0] win;
    } filter_job_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [WIN_W-1:0]   s_tdata  = '0;   // top_left .. bot_right, 24 bits each
    logic [0:0]         s_tuser  = '0;   // on_border
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [PIXEL_W-1:0] m_tdata;         // filtered_pixel

    filter_job_t pending_jobs[$];
    pixel_t      expected_pixels[$];
    filter_job_t next_job;
    pixel_t      want_pixel;
    logic        window_taken = 1'b0;
    int          send_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          idle_cycles = 0;
    int          errors = 0;

    median_filter_3x3_rgb i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // fifth smallest of the nine values of one channel
    function automatic chan_t channel_median(input filter_job_t job, input int ch);
        chan_t vals [WINDOW_SIZE];
        int    below;
        int    same;
        for (int i = 0; i < WINDOW_SIZE; i++)
            vals[i] = job.win[i*PIXEL_W + ch*CHAN_W +: CHAN_W];
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            below = 0;
            same  = 0;
            for (int k = 0; k < WINDOW_SIZE; k++)
            begin
                if (vals[k] < vals[i])
                    below++;
                else if (vals[k] == vals[i])
                    same++;
            end
            if (below <= MEDIAN_RANK && below + same > MEDIAN_RANK)
                return vals[i];
        end
        return '0;
    endfunction

    function automatic pixel_t filtered_pixel_of(input filter_job_t job);
        pixel_t res;
        res = job.win[CENTER_IDX*PIXEL_W +: PIXEL_W];
        if (!job.border)
            for (int ch = 0; ch < CHANNEL_COUNT && ch < PIXEL_CHANS; ch++)
                res[ch*CHAN_W +: CHAN_W] = channel_median(job, ch);
        return res;
    endfunction

    function automatic filter_job_t window_of(input pixel_t p0, input pixel_t p1,
                                              input pixel_t p2, input pixel_t p3,
                                              input pixel_t p4, input pixel_t p5,
                                              input pixel_t p6, input pixel_t p7,
                                              input pixel_t p8, input logic border);
        filter_job_t job;
        job.border = border;
        job.win    = {p8, p7, p6, p5, p4, p3, p2, p1, p0};
        return job;
    endfunction

    function automatic chan_t corner_byte();
        case ($urandom_range(6))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h7F;
            3: return 8'h80;
            4: return 8'hFE;
            5: return 8'hFF;
            default: return chan_t'($urandom);
        endcase
    endfunction

    function automatic filter_job_t random_window();
        filter_job_t job;
        pixel_t      base;
        pixel_t      pix;
        int          mode;
        mode = $urandom_range(9);
        base = pixel_t'($urandom);
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            case (mode)
                5, 6:
                    pix = {corner_byte(), corner_byte(), corner_byte()};
                7:
                    pix = ($urandom_range(3) == 0) ? pixel_t'($urandom) : base;
                8:
                    // narrow spread per channel gives many equal values
                    for (int ch = 0; ch < PIXEL_CHANS; ch++)
                        pix[ch*CHAN_W +: CHAN_W] = base[ch*CHAN_W +: CHAN_W]
                                                   + chan_t'($urandom_range(3));
                9:
                    pix = base;
                default:
                    pix = pixel_t'($urandom);
            endcase
            job.win[i*PIXEL_W +: PIXEL_W] = pix;
        end
        job.border = ($urandom_range(7) == 0);
        return job;
    endfunction

    task automatic run_phase(input int send_pct, input int stall_pct, input int count);
        send_idle_pct  = send_pct;
        sink_stall_pct = stall_pct;
        repeat (count)
            pending_jobs.push_back(random_window());
        while (pending_jobs.size() != 0 || s_tvalid)
            @(negedge clk);
    endtask

    // source side and sink ready, both driven on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || window_taken)
            begin
                if (pending_jobs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_job = pending_jobs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_job.win;
                    s_tuser  <= next_job.border;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // predict on input transfers, check on output transfers
    always @(posedge clk)
    begin
        window_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            expected_pixels.push_back(filtered_pixel_of({s_tuser[0], s_tdata}));
        if (m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected output transfer, filtered_pixel %06h", m_tdata);
                errors++;
            end
            else
            begin
                want_pixel = expected_pixels.pop_front();
                if (m_tdata !== want_pixel)
                begin
                    $error("filtered_pixel mismatch: expected %06h, actual %06h",
                           want_pixel, m_tdata);
                    errors++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("median_filter_3x3_rgb test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // extremes and border pass-through
        pending_jobs.push_back(window_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        pending_jobs.push_back(window_of('1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b0));
        pending_jobs.push_back(window_of(0, 0, 0, 0, '1, 0, 0, 0, 0, 1'b0));
        pending_jobs.push_back(window_of('1, '1, '1, '1, 0, '1, '1, '1, '1, 1'b0));
        pending_jobs.push_back(window_of(0, 0, 0, 0, '1, 0, 0, 0, 0, 1'b1));
        pending_jobs.push_back(window_of('1, '1, '1, '1, 0, '1, '1, '1, '1, 1'b1));
        pending_jobs.push_back(window_of(24'h123456, 24'hABCDEF, 24'h000000, 24'hFFFFFF,
                                         24'hA5C35A, 24'h5A3CA5, 24'h010101, 24'hFEFEFE,
                                         24'h808080, 1'b1));
        // channels ordered independently: B rising, G falling, R shuffled
        pending_jobs.push_back(window_of(24'h50_09_01, 24'h20_08_02, 24'h90_07_03,
                                         24'h10_06_04, 24'h70_05_05, 24'h30_04_06,
                                         24'h80_03_07, 24'h40_02_08, 24'h60_01_09, 1'b0));
        // five of one value, four of another
        pending_jobs.push_back(window_of(24'h11_22_33, 24'hEE_DD_CC, 24'h11_22_33,
                                         24'hEE_DD_CC, 24'h11_22_33, 24'hEE_DD_CC,
                                         24'h11_22_33, 24'hEE_DD_CC, 24'h11_22_33, 1'b0));
        pending_jobs.push_back(window_of(24'hEE_DD_CC, 24'h11_22_33, 24'hEE_DD_CC,
                                         24'h11_22_33, 24'h11_22_33, 24'hEE_DD_CC,
                                         24'h11_22_33, 24'hEE_DD_CC, 24'hEE_DD_CC, 1'b0));
        // single outliers in each channel
        pending_jobs.push_back(window_of(24'h404040, 24'h404040, 24'hFF0000,
                                         24'h404040, 24'h00FF00, 24'h404040,
                                         24'h0000FF, 24'h404040, 24'h404040, 1'b0));
        // alternating bit patterns
        pending_jobs.push_back(window_of(24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                                         24'h555555, 24'hAAAAAA, 24'h555555,
                                         24'hAAAAAA, 24'h555555, 24'h555555, 1'b0));
        pending_jobs.push_back(window_of(24'h7F807F, 24'h807F80, 24'h01FE01,
                                         24'hFE01FE, 24'h000000, 24'hFFFFFF,
                                         24'h7F7F7F, 24'h808080, 24'h010101, 1'b0));

        run_phase(0, 0, 360);
        run_phase(73, 0, 370);
        run_phase(0, 73, 370);
        run_phase(20, 20, 370);
        run_phase(0, 0, 370);

        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_pixels.size() != 0)
        begin
            $error("%0d filtered pixels never arrived", expected_pixels.size());
            errors++;
        end

        if (errors == 0)
            $display("median_filter_3x3_rgb test passed");
        else
            $display("median_filter_3x3_rgb test failed");
        $finish;
    end

endmodule

// File: filelist.f
src/mf3_pkg.sv
src/mf3_lane.sv
src/mf3_merge.sv
src/median_filter_3x3_rgb.sv
test/median_filter_3x3_rgb_tb.sv
